@@ hw/rtl/tps_pkg.sv @@
// Shared constants for the triangle plane slicer.
package tps_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Byte address of the slice height register
    localparam logic [APB_ADDR_W-1:0] ADDR_SLICE_HEIGHT = 3'd0;

endpackage

@@ hw/rtl/tps_front.sv @@
// Front end: register a triangle, classify it against the plane, set up both crossing edges.
module tps_front #(
    parameter int COORD_WIDTH = tps_pkg::COORD_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [COORD_WIDTH-1:0]    i_height,
    input  logic                      i_s_valid,
    output logic                      o_s_ready,
    input  logic [9*COORD_WIDTH-1:0]  i_s_data,
    output logic                      o_q_valid,
    input  logic                      i_q_ready,
    output logic [12*COORD_WIDTH+11:0] o_q_data
);
    import tps_pkg::*;

    localparam int W = COORD_WIDTH;

    typedef struct packed {
        logic [W-1:0] ax;
        logic [W-1:0] ay;
        logic [W:0]   dxa;
        logic [W:0]   dya;
        logic         xinc;
        logic         yinc;
        logic [W:0]   num;
        logic [W:0]   den;
    } t_edge;

    logic             r_fv;
    logic [9*W-1:0]   r_tri;
    logic [W-1:0]     vx [3];
    logic [W-1:0]     vy [3];
    logic [W-1:0]     vz [3];
    logic [2:0]       below;
    logic [2:0]       above;
    logic             hit;
    t_edge            e12, e13, e23, e_first, e_second;

    function automatic logic [W:0] abs_diff(input logic [W-1:0] p, input logic [W-1:0] q);
        logic [W:0] d;
        d = {p[W-1], p} - {q[W-1], q};
        return d[W] ? (~d + 1'b1) : d;
    endfunction

    function automatic t_edge mk_edge(input logic [W-1:0] ax, input logic [W-1:0] ay,
                                      input logic [W-1:0] az, input logic [W-1:0] bx,
                                      input logic [W-1:0] by, input logic [W-1:0] bz,
                                      input logic [W-1:0] h);
        t_edge e;
        e.ax   = ax;
        e.ay   = ay;
        e.dxa  = abs_diff(ax, bx);
        e.dya  = abs_diff(ay, by);
        e.xinc = $signed(ax) < $signed(bx);
        e.yinc = $signed(ay) < $signed(by);
        e.num  = abs_diff(az, h);
        e.den  = abs_diff(az, bz);
        return e;
    endfunction

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            vx[k]    = r_tri[(3*k)*W +: W];
            vy[k]    = r_tri[(3*k+1)*W +: W];
            vz[k]    = r_tri[(3*k+2)*W +: W];
            below[k] = $signed(vz[k]) < $signed(i_height);
            above[k] = $signed(vz[k]) > $signed(i_height);
        end
    end

    assign hit = (|below) & (|above);

    always_comb begin
        e12 = mk_edge(vx[0], vy[0], vz[0], vx[1], vy[1], vz[1], i_height);
        e13 = mk_edge(vx[0], vy[0], vz[0], vx[2], vy[2], vz[2], i_height);
        e23 = mk_edge(vx[1], vy[1], vz[1], vx[2], vy[2], vz[2], i_height);
        if (below[0] != below[1]) begin
            e_first  = e12;
            e_second = (below[0] != below[2]) ? e13 : e23;
        end else begin
            e_first  = e13;
            e_second = e23;
        end
    end

    assign o_q_valid = r_fv & hit;
    assign o_q_data  = {e_second, e_first};
    // drop a miss at once, hold a hit until the queue takes it
    assign o_s_ready = !r_fv || !hit || i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (o_s_ready) begin
            r_fv <= i_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_ready && i_s_valid) begin
            r_tri <= i_s_data;
        end
    end

endmodule

@@ hw/rtl/tps_queue.sv @@
// Small flop queue between the front and back ends.
module tps_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);
    import tps_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_cnt;
    logic             push, pop;

    assign o_push_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_data   = r_mem[r_rd];
    assign push         = i_push_valid & o_push_ready;
    assign pop          = o_pop_valid & i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

@@ hw/rtl/tps_back.sv @@
// Back end: pipelined restoring divider, scale multiply and endpoint add or subtract.
module tps_back #(
    parameter int COORD_WIDTH = tps_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = tps_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    output logic                       o_q_ready,
    input  logic [12*COORD_WIDTH+11:0] i_q_data,
    output logic                       o_m_valid,
    input  logic                       i_m_ready,
    output logic [4*COORD_WIDTH-1:0]   o_m_data
);
    import tps_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int PW = F + W + 2;

    typedef struct packed {
        logic [W-1:0] ax;
        logic [W-1:0] ay;
        logic [W:0]   dxa;
        logic [W:0]   dya;
        logic         xinc;
        logic         yinc;
        logic [W:0]   num;
        logic [W:0]   den;
    } t_edge;

    typedef struct packed {
        logic [W-1:0] ax;
        logic [W-1:0] ay;
        logic [W:0]   dxa;
        logic [W:0]   dya;
        logic         xinc;
        logic         yinc;
        logic [W+1:0] rem;
        logic [W:0]   den;
        logic [F:0]   q;
    } t_div;

    typedef struct packed {
        logic [W-1:0]  ax;
        logic [W-1:0]  ay;
        logic          xinc;
        logic          yinc;
        logic [PW-1:0] px;
        logic [PW-1:0] py;
    } t_mul;

    t_edge       q_edge [2];
    t_div        r_dv [F+1][2];
    logic [F:0]  r_dvv;
    t_mul        r_mp [2];
    logic        r_mv;
    logic [W-1:0] r_ox [2];
    logic [W-1:0] r_oy [2];
    logic        r_ov;
    logic        en;

    function automatic t_div div_step(input t_div d, input logic shift_in);
        t_div       o;
        logic [W+1:0] r;
        o = d;
        r = shift_in ? {d.rem[W:0], 1'b0} : d.rem;
        if (r >= {1'b0, d.den}) begin
            o.rem = r - {1'b0, d.den};
            o.q   = {d.q[F-1:0], 1'b1};
        end else begin
            o.rem = r;
            o.q   = {d.q[F-1:0], 1'b0};
        end
        return o;
    endfunction

    function automatic logic [W-1:0] place(input logic [W-1:0] a, input logic inc,
                                           input logic [PW-1:0] p);
        logic [W:0] off;
        logic [W:0] s;
        off = p[F +: W+1];
        s   = inc ? ({a[W-1], a} + off) : ({a[W-1], a} - off);
        return s[W-1:0];
    endfunction

    // advance the whole pipe unless the output register is held
    assign en        = !r_ov || i_m_ready;
    assign o_q_ready = en;
    assign q_edge[0] = i_q_data[0 +: 6*W+6];
    assign q_edge[1] = i_q_data[6*W+6 +: 6*W+6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvv <= '0;
            r_mv  <= 1'b0;
            r_ov  <= 1'b0;
        end else if (en) begin
            r_dvv <= {r_dvv[F-1:0], i_q_valid};
            r_mv  <= r_dvv[F];
            r_ov  <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int e = 0; e < 2; e++) begin
                t_div d0;
                d0.ax   = q_edge[e].ax;
                d0.ay   = q_edge[e].ay;
                d0.dxa  = q_edge[e].dxa;
                d0.dya  = q_edge[e].dya;
                d0.xinc = q_edge[e].xinc;
                d0.yinc = q_edge[e].yinc;
                d0.rem  = {1'b0, q_edge[e].num};
                d0.den  = q_edge[e].den;
                d0.q    = '0;
                r_dv[0][e] <= div_step(d0, 1'b0);
                for (int k = 1; k <= F; k++) begin
                    r_dv[k][e] <= div_step(r_dv[k-1][e], 1'b1);
                end
                r_mp[e].ax   <= r_dv[F][e].ax;
                r_mp[e].ay   <= r_dv[F][e].ay;
                r_mp[e].xinc <= r_dv[F][e].xinc;
                r_mp[e].yinc <= r_dv[F][e].yinc;
                r_mp[e].px   <= PW'(r_dv[F][e].q) * PW'(r_dv[F][e].dxa);
                r_mp[e].py   <= PW'(r_dv[F][e].q) * PW'(r_dv[F][e].dya);
                r_ox[e] <= place(r_mp[e].ax, r_mp[e].xinc, r_mp[e].px);
                r_oy[e] <= place(r_mp[e].ay, r_mp[e].yinc, r_mp[e].py);
            end
        end
    end

    assign o_m_valid = r_ov;
    assign o_m_data  = {r_oy[1], r_ox[1], r_oy[0], r_ox[0]};

endmodule

@@ hw/rtl/triangle_plane_slicer_core.sv @@
// Triangle plane slicer top level: APB register, front end, queue and back end.
//
// Cuts each streamed triangle (three vertices, signed fixed point) with the plane
// z = slice_height and emits one segment (start_x, start_y, end_x, end_y) for a
// triangle whose lowest vertex lies strictly below the plane and whose highest lies
// strictly above; other triangles give no transaction. A new triangle is taken every
// cycle while the output keeps flowing. From the input register a triangle passes
// through the queue, FRAC_BITS + 1 restoring divider stages computing the crossing
// fraction, one multiply stage and the output register. A held output stalls the back
// end; the four-entry queue lets the front end keep accepting until it fills. Write the
// slice height only while no triangle is in flight.
module triangle_plane_slicer_core #(
    parameter int COORD_WIDTH = tps_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = tps_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z from bit 0 up
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]    i_s_tdata,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // start_x, start_y, end_x, end_y from bit 0 up
    output logic [((4*COORD_WIDTH+7)/8)*8-1:0]    o_m_tdata,
    input  logic                                  i_psel,
    input  logic                                  i_penable,
    input  logic                                  i_pwrite,
    input  logic [tps_pkg::APB_ADDR_W-1:0]        i_paddr,
    input  logic [tps_pkg::APB_DATA_W-1:0]        i_pwdata,
    output logic [tps_pkg::APB_DATA_W-1:0]        o_prdata,
    output logic                                  o_pready
);
    import tps_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int OW  = ((4*W+7)/8)*8;
    localparam int EW  = 12*W+12;

    logic [W-1:0]   r_height;
    logic [W-1:0]   wr_height;
    logic           cfg_wr;
    logic           f_valid, f_ready;
    logic [EW-1:0]  f_data;
    logic           b_valid, b_ready;
    logic [EW-1:0]  b_data;
    logic [4*W-1:0] seg;

    // APB: no wait states; write the height on the access phase
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel & i_penable & i_pwrite & o_pready
                      & (i_paddr == ADDR_SLICE_HEIGHT);

    generate
        if (W >= APB_DATA_W) begin : g_wide
            assign wr_height = W'($signed(i_pwdata));
            assign o_prdata  = (i_paddr == ADDR_SLICE_HEIGHT) ? r_height[APB_DATA_W-1:0]
                                                              : '0;
        end else begin : g_narrow
            assign wr_height = i_pwdata[W-1:0];
            assign o_prdata  = (i_paddr == ADDR_SLICE_HEIGHT)
                               ? {{(APB_DATA_W-W){r_height[W-1]}}, r_height} : '0;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= '0;
        end else if (cfg_wr) begin
            r_height <= wr_height;
        end
    end

    tps_front #(.COORD_WIDTH(W)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_height  (r_height),
        .i_s_valid (i_s_tvalid),
        .o_s_ready (o_s_tready),
        .i_s_data  (i_s_tdata[9*W-1:0]),
        .o_q_valid (f_valid),
        .i_q_ready (f_ready),
        .o_q_data  (f_data)
    );

    tps_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH_DEF)) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  (f_data),
        .o_pop_valid  (b_valid),
        .i_pop_ready  (b_ready),
        .o_pop_data   (b_data)
    );

    tps_back #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (b_valid),
        .o_q_ready (b_ready),
        .i_q_data  (b_data),
        .o_m_valid (o_m_tvalid),
        .i_m_ready (i_m_tready),
        .o_m_data  (seg)
    );

    assign o_m_tdata = OW'(seg);

endmodule

@@ hw/rtl/tps_checker.sv @@
// Port-level checker for the triangle plane slicer, bound to the top level.
module tps_checker #(
    parameter int COORD_WIDTH = tps_pkg::COORD_WIDTH_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [((4*COORD_WIDTH+7)/8)*8-1:0] o_m_tdata,
    input logic                               i_psel,
    input logic                               i_penable,
    input logic                               i_pwrite,
    input logic [tps_pkg::APB_ADDR_W-1:0]     i_paddr,
    input logic [tps_pkg::APB_DATA_W-1:0]     i_pwdata,
    input logic [tps_pkg::APB_DATA_W-1:0]     o_prdata,
    input logic                               o_pready
);
    import tps_pkg::*;

    // reset empties the back end
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid) else $error("segment valid after reset");

    // hold a stalled segment
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled segment changed");

    a_ready: assert property (@(posedge i_clk) o_pready)
        else $error("pready dropped");

    generate
        if (COORD_WIDTH == APB_DATA_W) begin : g_rb
            // a written height reads back as soon as it is registered
            a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                i_psel && i_penable && i_pwrite && i_paddr == ADDR_SLICE_HEIGHT
                ##1 i_paddr == ADDR_SLICE_HEIGHT |-> o_prdata == $past(i_pwdata))
                else $error("height readback mismatch");
        end
    endgenerate

endmodule

bind triangle_plane_slicer_core tps_checker #(.COORD_WIDTH(COORD_WIDTH)) u_tps_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .i_psel     (i_psel),
    .i_penable  (i_penable),
    .i_pwrite   (i_pwrite),
    .i_paddr    (i_paddr),
    .i_pwdata   (i_pwdata),
    .o_prdata   (o_prdata),
    .o_pready   (o_pready)
);

@@ verif/triangle_plane_slicer_core_tb.sv @@
// Self-checking testbench for the triangle plane slicer: segment prediction and scoreboard.
`timescale 1ns / 100ps

module triangle_plane_slicer_core_tb;

    localparam int CW = tps_pkg::COORD_WIDTH_DEF;
    localparam int FB = tps_pkg::FRAC_BITS_DEF;
    localparam int LATENCY = FB + 4;
    localparam int N_RANDOM = 1200;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [CW-1:0] x, y, z;
    } t_vertex;

    typedef struct {
        logic signed [CW-1:0] sx, sy, ex, ey;
    } t_segment;

    // Work out the crossing point of edge (a,b) with the plane at height h
    function automatic void edge_cross(input t_vertex a, input t_vertex b,
                                       input logic signed [CW-1:0] h,
                                       output logic signed [CW-1:0] ox,
                                       output logic signed [CW-1:0] oy);
        longint az, bz, hz, ax, bx, ay, by;
        longint unsigned num, den, frac, dxa, dya, offx, offy;
        az = a.z; bz = b.z; hz = h;
        ax = a.x; bx = b.x; ay = a.y; by = b.y;
        num = (az < hz) ? hz - az : az - hz;
        den = (az < bz) ? bz - az : az - bz;
        frac = (den != 0) ? (num << FB) / den : 0;
        dxa = (ax < bx) ? bx - ax : ax - bx;
        dya = (ay < by) ? by - ay : ay - by;
        offx = (frac * dxa) >> FB;
        offy = (frac * dya) >> FB;
        ox = CW'((ax < bx) ? ax + longint'(offx) : ax - longint'(offx));
        oy = CW'((ay < by) ? ay + longint'(offy) : ay - longint'(offy));
    endfunction

    // Predict the segment for a triangle; return 0 where the plane misses it
    function automatic bit slice_triangle(input t_vertex v[3],
                                          input logic signed [CW-1:0] h,
                                          output t_segment seg);
        logic signed [CW-1:0] lo, hi;
        bit b1, b2, b3;
        lo = v[0].z; hi = v[0].z;
        for (int i = 1; i < 3; i++) begin
            if (v[i].z < lo) lo = v[i].z;
            if (v[i].z > hi) hi = v[i].z;
        end
        if (!(lo < h && hi > h)) return 0;
        b1 = v[0].z < h; b2 = v[1].z < h; b3 = v[2].z < h;
        if (b1 != b2) begin
            edge_cross(v[0], v[1], h, seg.sx, seg.sy);
            if (b1 != b3) edge_cross(v[0], v[2], h, seg.ex, seg.ey);
            else edge_cross(v[1], v[2], h, seg.ex, seg.ey);
        end else begin
            edge_cross(v[0], v[2], h, seg.sx, seg.sy);
            edge_cross(v[1], v[2], h, seg.ex, seg.ey);
        end
        return 1;
    endfunction

    class segment_scoreboard;
        t_segment pending[$];
        logic signed [CW-1:0] height;
        int errors;

        function void note_triangle(t_vertex v[3]);
            t_segment s;
            if (slice_triangle(v, height, s)) pending = {pending, s};
        endfunction

        function void check_segment(t_segment got);
            t_segment want;
            if (pending.size() == 0) begin
                $error("segment with none expected: %h %h %h %h",
                       got.sx, got.sy, got.ex, got.ey);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.sx !== want.sx) begin
                $error("start_x expected %h actual %h", want.sx, got.sx); errors++;
            end
            if (got.sy !== want.sy) begin
                $error("start_y expected %h actual %h", want.sy, got.sy); errors++;
            end
            if (got.ex !== want.ex) begin
                $error("end_x expected %h actual %h", want.ex, got.ex); errors++;
            end
            if (got.ey !== want.ey) begin
                $error("end_y expected %h actual %h", want.ey, got.ey); errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic i_s_tvalid, o_s_tready;
    logic [((9*CW+7)/8)*8-1:0] i_s_tdata;   // v1_x..v3_z from bit 0 up
    logic o_m_tvalid, i_m_tready;
    logic [((4*CW+7)/8)*8-1:0] o_m_tdata;   // start_x, start_y, end_x, end_y from bit 0 up
    logic i_psel, i_penable, i_pwrite;
    logic [tps_pkg::APB_ADDR_W-1:0] i_paddr;
    logic [tps_pkg::APB_DATA_W-1:0] i_pwdata, o_prdata;
    logic o_pready;

    segment_scoreboard sb;
    longint cycles;
    bit stall_mode;

    triangle_plane_slicer_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Output side: stall at random, check each accepted transaction
    always @(posedge i_clk) begin
        t_segment got;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got.sx = o_m_tdata[0*CW +: CW];
                got.sy = o_m_tdata[1*CW +: CW];
                got.ex = o_m_tdata[2*CW +: CW];
                got.ey = o_m_tdata[3*CW +: CW];
                sb.check_segment(got);
            end
            i_m_tready <= stall_mode ? ($urandom_range(0, 9) < 3)
                                     : ($urandom_range(0, 9) < 9);
        end
    end

    // Hold an APB write through setup and access
    task automatic write_height(input logic signed [CW-1:0] h);
        i_psel <= 1'b1; i_pwrite <= 1'b1; i_penable <= 1'b0;
        i_paddr <= tps_pkg::ADDR_SLICE_HEIGHT; i_pwdata <= h;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        i_psel <= 1'b0; i_penable <= 1'b0; i_pwrite <= 1'b0;
        sb.height = h;
    endtask

    // Present one triangle and hold it until the transaction completes
    task automatic send_triangle(input t_vertex v[3]);
        int g;
        g = gap_len();
        if (g != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        for (int i = 0; i < 3; i++) begin
            i_s_tdata[(3*i+0)*CW +: CW] <= v[i].x;
            i_s_tdata[(3*i+1)*CW +: CW] <= v[i].y;
            i_s_tdata[(3*i+2)*CW +: CW] <= v[i].z;
        end
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_triangle(v);
    endtask

    // Wait for all segments, then let a missed triangle drain
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            1: return $signed($urandom_range(0, 64)) - 32;
            default: return $urandom();
        endcase
    endfunction

    // Random triangle; mostly straddles h so segments are common
    function automatic void rand_triangle(input logic signed [CW-1:0] h,
                                          output t_vertex v[3]);
        longint lo_span, hi_span;
        for (int i = 0; i < 3; i++) begin
            v[i].x = rand_coord();
            v[i].y = rand_coord();
            v[i].z = rand_coord();
        end
        if ($urandom_range(0, 9) < 7) begin
            lo_span = longint'(h) + 2147483648;
            hi_span = 2147483647 - longint'(h);
            for (int i = 0; i < 3; i++) begin
                case ($urandom_range(0, 6))
                    0: v[i].z = h;
                    1, 2, 3: if (lo_span > 0) v[i].z = CW'(longint'(h)
                        - 1 - longint'($urandom()) % lo_span);
                    default: if (hi_span > 0) v[i].z = CW'(longint'(h)
                        + 1 + longint'($urandom()) % hi_span);
                endcase
            end
        end
    endfunction

    function automatic t_vertex vtx(int x, int y, int z);
        t_vertex v;
        v.x = x; v.y = y; v.z = z;
        return v;
    endfunction

    initial begin
        t_vertex tv[3];
        logic signed [CW-1:0] heights[6];
        sb = new();
        sb.height = 0;
        cycles = 0; stall_mode = 0;
        i_rst_n = 1'b0; i_s_tvalid = 1'b0; i_s_tdata = '0; i_m_tready = 1'b0;
        i_psel = 1'b0; i_penable = 1'b0; i_pwrite = 1'b0; i_paddr = '0; i_pwdata = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: plane at reset height zero
        tv = '{vtx(0, 0, -65536), vtx(65536, 65536, 65536), vtx(-65536, 0, 65536)};
        send_triangle(tv);
        tv = '{vtx(0, 0, 0), vtx(5, 5, 100), vtx(7, 7, 200)};       // vertex on plane, miss
        send_triangle(tv);
        tv = '{vtx(0, 0, 0), vtx(5, 9, -100), vtx(7, 3, 200)};      // vertex on plane, cut
        send_triangle(tv);
        tv = '{vtx(3, 3, 10), vtx(8, 8, -10), vtx(1, 1, -20)};      // v1 differs from v2
        send_triangle(tv);
        tv = '{vtx(3, 3, 10), vtx(8, 8, -10), vtx(1, 1, 20)};       // v1 matches v3
        send_triangle(tv);
        tv = '{vtx(3, 3, 10), vtx(8, 8, 10), vtx(1, 1, -20)};       // v1 matches v2
        send_triangle(tv);
        tv = '{vtx(4, 4, -1), vtx(4, 4, 1), vtx(4, 4, 1)};          // equal x and y
        send_triangle(tv);
        tv = '{vtx(32'sh7fffffff, 32'sh80000000, 32'sh80000000),
               vtx(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff),
               vtx(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff)};   // extremes
        send_triangle(tv);
        tv = '{vtx(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff),
               vtx(32'sh7fffffff, 32'sh80000000, 32'sh80000000),
               vtx(0, 0, 1)};
        send_triangle(tv);
        tv = '{vtx(1, 1, 5), vtx(2, 2, 6), vtx(3, 3, 7)};           // all above
        send_triangle(tv);
        tv = '{vtx(1, 1, -5), vtx(2, 2, -6), vtx(3, 3, -7)};        // all below
        send_triangle(tv);
        drain();

        // Extreme heights, then a random height and 0x00010000
        heights = '{32'sh7fffffff, 32'sh80000000, 32'sh7ffffffe, 32'sh80000001, 0, 0};
        heights[4] = $urandom(); heights[5] = 32'sh00010000;
        for (int p = 0; p < 6; p++) begin
            write_height(heights[p]);
            stall_mode = p[0];
            tv = '{vtx(-1, 2, heights[p]), vtx(9, -9, heights[p] - 1),
                   vtx(7, 7, heights[p] + 1)};
            send_triangle(tv);
            for (int n = 0; n < N_RANDOM / 6; n++) begin
                rand_triangle(heights[p], tv);
                send_triangle(tv);
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
